FILE: hw/rtl/rgb_led_pattern_sequencer_core_defines.svh
// Assertion helpers for the LED sequencer checker.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef RGB_LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define RGB_LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RLPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rlps_pkg.sv
`timescale 1ns / 1ps

package rlps_pkg;

    // Command codes carried in the op field
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_OFF   = 3'd1,
        OP_SOLID = 3'd2,
        OP_START = 3'd3,
        OP_WRITE = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] hue;
        logic [7:0]  repeat_param;
        logic [3:0]  entry_index;
        logic [7:0]  entry_cycles;
        logic [7:0]  entry_on_time;
        logic [7:0]  entry_off_time;
    } t_in_item;

    typedef struct packed {
        logic [15:0] red_pulse;
        logic [15:0] green_pulse;
        logic [15:0] blue_pulse;
        logic        pattern_running;
        logic        lit_phase;
        logic        walk_overrun;
    } t_out_item;

    // One pattern table entry as stored in the RAM
    typedef struct packed {
        logic [7:0]  off_ticks;
        logic [7:0]  on_time;
        logic [7:0]  cycles;
        logic [15:0] hue;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_ADV_RD,
        S_ADV_EVAL,
        S_COL_HUE,
        S_COL_LVL,
        S_COL_MUL,
        S_COL_GAIN,
        S_FINISH
    } t_state;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_COUNT,
        DP_FIRE,
        DP_OFF,
        DP_SOLID,
        DP_START,
        DP_RESUME,
        DP_WRITE,
        DP_READ,
        DP_EVAL,
        DP_OVERRUN,
        DP_COL_HUE,
        DP_COL_LVL,
        DP_COL_MUL,
        DP_COL_GAIN,
        DP_LOAD_OUT
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic armed;
        logic cd_le1;
        logic running;
        logic lit;
        logic same_param;
        logic walk_done;
        logic ent_cycles_nz;
        logic ent_on_nz;
        logic ent_off_nz;
        logic ch_last;
        logic out_free;
    } t_dp_status;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [26:0] HUE_SCALE    = 27'd1536;
    localparam logic [26:0] HUE_ROUND    = 27'h8000;
    localparam logic [10:0] LEVEL_FULL   = 11'd256;
    localparam logic [10:0] SEG_1        = 11'd256;
    localparam logic [10:0] SEG_2        = 11'd512;
    localparam logic [10:0] SEG_3        = 11'd768;
    localparam logic [10:0] SEG_4        = 11'd1024;
    localparam logic [10:0] SEG_5        = 11'd1280;
    localparam logic [10:0] SEG_6        = 11'd1536;
    localparam logic [7:0]  CC_MAX       = 8'd255;
    localparam logic [1:0]  CH_LAST      = 2'd2;

    // Per-channel gains in 1/64 units: red, green, blue
    localparam logic [4:0] CH_GAIN [0:2] = '{5'd20, 5'd8, 5'd12};

endpackage

FILE: hw/rtl/rlps_ram.sv
`timescale 1ns / 1ps

module rlps_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/rlps_datapath.sv
`timescale 1ns / 1ps

module rlps_datapath #(
    parameter int TABLE_DEPTH     = 16,
    parameter int SENTINEL_CYCLES = 255,
    parameter int WALK_LIMIT      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlps_pkg::t_dp_cmd   i_cmd,
    output rlps_pkg::t_dp_status o_status,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  rlps_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rlps_pkg::t_out_item o_out_data
);

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int IDX_W   = (SLOT_W > 4) ? SLOT_W : 4;
    localparam int WALK_W  = $clog2(WALK_LIMIT + 1);

    // Architectural state
    rlps_pkg::t_in_item  r_in;
    logic [15:0]         r_period;
    logic                r_running;
    logic [SLOT_W-1:0]   r_slot;
    logic [7:0]          r_cc;
    logic [7:0]          r_held;
    logic                r_lit;
    logic [7:0]          r_countdown;
    logic                r_armed;
    logic [15:0]         r_pulse [0:2];
    logic [WALK_W-1:0]   r_walk;
    logic                r_overrun;

    // Color pipeline
    logic [15:0]         r_col_hue;
    logic [10:0]         r_wheel;
    logic [8:0]          r_lvl [0:2];
    logic [1:0]          r_ch;
    logic [24:0]         r_prod;

    rlps_pkg::t_out_item r_out;
    logic                r_out_valid;

    // Table RAM
    logic [rlps_pkg::ENTRY_W-1:0] rd_data;
    rlps_pkg::t_entry             ent;
    rlps_pkg::t_entry             wr_ent;
    logic [IDX_W-1:0]             idx_ext;
    logic                         wr_ok;

    // Walk step
    logic [7:0]          lim;
    logic [7:0]          cc_inc;
    logic                cc_hit;
    logic [SLOT_W:0]     slot_inc;
    logic [SLOT_W-1:0]   slot_next;

    // Color
    logic [26:0]         wheel_sum;
    logic [10:0]         lv_r, lv_g, lv_b;
    logic [21:0]         gain_prod;

    assign ent     = rlps_pkg::t_entry'(rd_data);
    assign idx_ext = IDX_W'(r_in.entry_index);
    assign wr_ok   = (i_cmd == rlps_pkg::DP_WRITE) && (32'(r_in.entry_index) < TABLE_DEPTH);
    assign wr_ent  = '{off_ticks: r_in.entry_off_time, on_time: r_in.entry_on_time,
                       cycles: r_in.entry_cycles, hue: r_in.hue};

    rlps_ram #(
        .WIDTH (rlps_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_ok),
        .i_wr_addr (idx_ext[SLOT_W-1:0]),
        .i_wr_data (wr_ent),
        .i_rd_en   (i_cmd == rlps_pkg::DP_READ),
        .i_rd_addr (r_slot),
        .o_rd_data (rd_data)
    );

    assign lim       = (ent.cycles == 8'(SENTINEL_CYCLES)) ? r_held : ent.cycles;
    assign cc_inc    = (r_cc < rlps_pkg::CC_MAX) ? r_cc + 8'd1 : r_cc;
    assign cc_hit    = cc_inc >= lim;
    assign slot_inc  = {1'b0, r_slot} + (SLOT_W+1)'(1);
    assign slot_next = (slot_inc >= (SLOT_W+1)'(TABLE_DEPTH)) ? '0 : slot_inc[SLOT_W-1:0];

    // Hue onto a 0..1536 wheel, rounded
    assign wheel_sum = 27'(r_col_hue) * rlps_pkg::HUE_SCALE + rlps_pkg::HUE_ROUND;

    // Six-segment wheel to RGB levels
    always_comb begin
        lv_r = '0;
        lv_g = '0;
        lv_b = '0;
        if (r_wheel < rlps_pkg::SEG_2) begin
            if (r_wheel < rlps_pkg::SEG_1) begin
                lv_g = r_wheel;
                lv_r = rlps_pkg::LEVEL_FULL;
            end else begin
                lv_r = rlps_pkg::SEG_2 - r_wheel;
                lv_g = rlps_pkg::LEVEL_FULL;
            end
        end else if (r_wheel < rlps_pkg::SEG_4) begin
            if (r_wheel < rlps_pkg::SEG_3) begin
                lv_b = r_wheel - rlps_pkg::SEG_2;
                lv_g = rlps_pkg::LEVEL_FULL;
            end else begin
                lv_g = rlps_pkg::SEG_4 - r_wheel;
                lv_b = rlps_pkg::LEVEL_FULL;
            end
        end else begin
            if (r_wheel < rlps_pkg::SEG_5) begin
                lv_r = r_wheel - rlps_pkg::SEG_4;
                lv_b = rlps_pkg::LEVEL_FULL;
            end else begin
                lv_b = rlps_pkg::SEG_6 - r_wheel;
                lv_r = rlps_pkg::LEVEL_FULL;
            end
        end
    end

    assign gain_prod = 22'(r_prod[24:8]) * 22'(rlps_pkg::CH_GAIN[r_ch]);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= rlps_pkg::PERIOD_RESET;
            r_running   <= 1'b0;
            r_slot      <= '0;
            r_cc        <= '0;
            r_held      <= '0;
            r_lit       <= 1'b0;
            r_countdown <= '0;
            r_armed     <= 1'b0;
            r_pulse     <= '{16'd0, 16'd0, 16'd0};
            r_walk      <= '0;
            r_overrun   <= 1'b0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            unique case (i_cmd)
                rlps_pkg::DP_CAPTURE: begin
                    r_overrun <= 1'b0;
                end
                rlps_pkg::DP_COUNT: begin
                    r_countdown <= r_countdown - 8'd1;
                end
                rlps_pkg::DP_FIRE: begin
                    r_armed     <= 1'b0;
                    r_countdown <= '0;
                    r_walk      <= '0;
                    if (!r_running && r_lit) begin
                        r_pulse <= '{16'd0, 16'd0, 16'd0};
                    end
                end
                rlps_pkg::DP_OFF: begin
                    r_running <= 1'b0;
                    r_lit     <= 1'b0;
                    r_pulse   <= '{16'd0, 16'd0, 16'd0};
                end
                rlps_pkg::DP_SOLID: begin
                    r_running <= 1'b0;
                    r_lit     <= 1'b0;
                end
                rlps_pkg::DP_START: begin
                    r_running <= 1'b1;
                    r_held    <= r_in.repeat_param;
                    r_slot    <= '0;
                    r_cc      <= '0;
                    r_lit     <= 1'b0;
                    r_walk    <= '0;
                end
                rlps_pkg::DP_RESUME: begin
                    if (!r_lit) begin
                        r_pulse <= '{16'd0, 16'd0, 16'd0};
                    end
                end
                rlps_pkg::DP_EVAL: begin
                    r_walk <= r_walk + WALK_W'(1);
                    if (!r_lit) begin
                        if (ent.cycles != 8'd0) begin
                            r_lit       <= 1'b1;
                            r_armed     <= 1'b1;
                            r_countdown <= ent.on_time;
                        end else if (ent.on_time == 8'd0) begin
                            r_slot <= '0;
                            r_cc   <= '0;
                            if (ent.off_ticks != 8'd0) begin
                                r_armed     <= 1'b1;
                                r_countdown <= ent.off_ticks;
                            end
                        end
                    end else begin
                        if (cc_hit) begin
                            r_slot <= slot_next;
                            r_cc   <= '0;
                        end else begin
                            r_cc <= cc_inc;
                        end
                        r_lit <= 1'b0;
                        if (ent.off_ticks != 8'd0) begin
                            r_pulse     <= '{16'd0, 16'd0, 16'd0};
                            r_armed     <= 1'b1;
                            r_countdown <= ent.off_ticks;
                        end
                    end
                end
                rlps_pkg::DP_OVERRUN: begin
                    r_overrun <= 1'b1;
                end
                rlps_pkg::DP_COL_LVL: begin
                    r_ch <= '0;
                end
                rlps_pkg::DP_COL_GAIN: begin
                    r_pulse[r_ch] <= gain_prod[21:6];
                    r_ch          <= r_ch + 2'd1;
                end
                default: begin
                end
            endcase
            if (i_cmd == rlps_pkg::DP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            rlps_pkg::DP_CAPTURE: begin
                r_in <= i_in_data;
            end
            rlps_pkg::DP_SOLID: begin
                r_col_hue <= r_in.hue;
            end
            rlps_pkg::DP_EVAL: begin
                r_col_hue <= ent.hue;
            end
            rlps_pkg::DP_COL_HUE: begin
                r_wheel <= wheel_sum[26:16];
            end
            rlps_pkg::DP_COL_LVL: begin
                r_lvl[0] <= lv_r[8:0];
                r_lvl[1] <= lv_g[8:0];
                r_lvl[2] <= lv_b[8:0];
            end
            rlps_pkg::DP_COL_MUL: begin
                r_prod <= 25'(r_lvl[r_ch]) * 25'(r_period);
            end
            rlps_pkg::DP_LOAD_OUT: begin
                r_out <= '{red_pulse: r_pulse[0], green_pulse: r_pulse[1],
                           blue_pulse: r_pulse[2], pattern_running: r_running,
                           lit_phase: r_lit, walk_overrun: r_overrun};
            end
            default: begin
            end
        endcase
    end

    assign o_status = '{
        op:            rlps_pkg::t_op'(r_in.op),
        armed:         r_armed,
        cd_le1:        (r_countdown <= 8'd1),
        running:       r_running,
        lit:           r_lit,
        same_param:    (r_held == r_in.repeat_param),
        walk_done:     (r_walk == WALK_W'(WALK_LIMIT)),
        ent_cycles_nz: (ent.cycles != 8'd0),
        ent_on_nz:     (ent.on_time != 8'd0),
        ent_off_nz:    (ent.off_ticks != 8'd0),
        ch_last:       (r_ch == rlps_pkg::CH_LAST),
        out_free:      (!r_out_valid || !i_out_stall)
    };

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/rlps_ctrl.sv
`timescale 1ns / 1ps

module rlps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rlps_pkg::t_dp_status i_status,
    output rlps_pkg::t_dp_cmd    o_cmd
);

    rlps_pkg::t_state r_state;
    rlps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rlps_pkg::S_DISP;
                end
            end
            rlps_pkg::S_DISP: begin
                n_state = rlps_pkg::S_FINISH;
                case (i_status.op)
                    rlps_pkg::OP_TICK: begin
                        if (i_status.armed && i_status.cd_le1 && i_status.running) begin
                            n_state = rlps_pkg::S_ADV_RD;
                        end
                    end
                    rlps_pkg::OP_SOLID: begin
                        n_state = rlps_pkg::S_COL_HUE;
                    end
                    rlps_pkg::OP_START: begin
                        if (!i_status.running || !i_status.same_param) begin
                            n_state = rlps_pkg::S_ADV_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rlps_pkg::S_ADV_RD: begin
                n_state = i_status.walk_done ? rlps_pkg::S_FINISH : rlps_pkg::S_ADV_EVAL;
            end
            rlps_pkg::S_ADV_EVAL: begin
                if (!i_status.lit) begin
                    priority if (i_status.ent_cycles_nz) begin
                        n_state = rlps_pkg::S_COL_HUE;
                    end else if (i_status.ent_on_nz || i_status.ent_off_nz) begin
                        n_state = rlps_pkg::S_FINISH;
                    end else begin
                        n_state = rlps_pkg::S_ADV_RD;
                    end
                end else begin
                    n_state = i_status.ent_off_nz ? rlps_pkg::S_FINISH : rlps_pkg::S_ADV_RD;
                end
            end
            rlps_pkg::S_COL_HUE:  n_state = rlps_pkg::S_COL_LVL;
            rlps_pkg::S_COL_LVL:  n_state = rlps_pkg::S_COL_MUL;
            rlps_pkg::S_COL_MUL:  n_state = rlps_pkg::S_COL_GAIN;
            rlps_pkg::S_COL_GAIN: begin
                n_state = i_status.ch_last ? rlps_pkg::S_FINISH : rlps_pkg::S_COL_MUL;
            end
            rlps_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = rlps_pkg::S_IDLE;
                end
            end
            default: n_state = rlps_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = rlps_pkg::DP_NONE;
        o_in_stall = (r_state != rlps_pkg::S_IDLE);
        unique case (r_state)
            rlps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = rlps_pkg::DP_CAPTURE;
                end
            end
            rlps_pkg::S_DISP: begin
                case (i_status.op)
                    rlps_pkg::OP_TICK: begin
                        if (i_status.armed) begin
                            o_cmd = i_status.cd_le1 ? rlps_pkg::DP_FIRE : rlps_pkg::DP_COUNT;
                        end
                    end
                    rlps_pkg::OP_OFF:   o_cmd = rlps_pkg::DP_OFF;
                    rlps_pkg::OP_SOLID: o_cmd = rlps_pkg::DP_SOLID;
                    rlps_pkg::OP_START: begin
                        o_cmd = (!i_status.running || !i_status.same_param) ?
                                rlps_pkg::DP_START : rlps_pkg::DP_RESUME;
                    end
                    rlps_pkg::OP_WRITE: o_cmd = rlps_pkg::DP_WRITE;
                    default:            o_cmd = rlps_pkg::DP_NONE;
                endcase
            end
            rlps_pkg::S_ADV_RD: begin
                o_cmd = i_status.walk_done ? rlps_pkg::DP_OVERRUN : rlps_pkg::DP_READ;
            end
            rlps_pkg::S_ADV_EVAL: o_cmd = rlps_pkg::DP_EVAL;
            rlps_pkg::S_COL_HUE:  o_cmd = rlps_pkg::DP_COL_HUE;
            rlps_pkg::S_COL_LVL:  o_cmd = rlps_pkg::DP_COL_LVL;
            rlps_pkg::S_COL_MUL:  o_cmd = rlps_pkg::DP_COL_MUL;
            rlps_pkg::S_COL_GAIN: o_cmd = rlps_pkg::DP_COL_GAIN;
            rlps_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd = rlps_pkg::DP_LOAD_OUT;
                end
            end
            default: o_cmd = rlps_pkg::DP_NONE;
        endcase
    end

endmodule

FILE: hw/rtl/rgb_led_pattern_sequencer_core.sv
`timescale 1ns / 1ps
// RGB status LED pattern sequencer.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one command
// transaction: tick, off, solid hue, start pattern or write table entry.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
// transaction per command: the three PWM pulse widths plus running, lit and
// walk-overrun flags. i_cfg_wr_en / i_cfg_wr_data set the PWM period.
// From accept to result valid: tick, off, write and resume go from dispatch
// to the result load; solid hue adds the color steps; start and a tick that
// fires while running walk the table, plus the color steps if an entry lights
// the LED. The walk visits at most WALK_LIMIT entries; each visit costs a
// registered table read plus an evaluate step, and the color path runs its
// shared multipliers over the three channels in turn. Items are handled one
// at a time; the next one is taken in the cycle after the result is loaded.
// Reset (synchronous, active low) clears the pattern state and pulses, sets
// the period to 1000 and empties the output register; the table is not
// cleared and must be written before a pattern reads it.
// A stalled result holds in the output register; one further command can be
// accepted meanwhile, but its result waits until the register is free.

module rgb_led_pattern_sequencer_core #(
    parameter int TABLE_DEPTH     = 16,
    parameter int SENTINEL_CYCLES = 255,
    parameter int WALK_LIMIT      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rlps_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rlps_pkg::t_out_item o_out_data
);

    // Controller <-> datapath
    rlps_pkg::t_dp_cmd    dp_cmd;
    rlps_pkg::t_dp_status dp_status;

    // Sequencing: dispatch, table walk, color steps, result load
    rlps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // State registers, pattern table, color math and output register
    rlps_datapath #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .SENTINEL_CYCLES (SENTINEL_CYCLES),
        .WALK_LIMIT      (WALK_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

FILE: hw/rtl/rlps_checker.sv
`timescale 1ns / 1ps
`include "rgb_led_pattern_sequencer_core_defines.svh"

module rlps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rlps_pkg::t_out_item o_out_data
);

    `RLPS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")
    `RLPS_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !o_in_stall, o_in_stall, "second transaction taken while busy")
    `RLPS_ASSERT_NOW(a_lit_running, o_out_valid, !o_out_data.lit_phase || o_out_data.pattern_running, "lit without pattern")
    `RLPS_ASSERT_NOW(a_overrun_running, o_out_valid && o_out_data.walk_overrun, o_out_data.pattern_running, "overrun without pattern")

endmodule

bind rgb_led_pattern_sequencer_core rlps_checker u_rlps_checker (.*);
